// ----- rtl/ssw_pkg.sv -----
// Shared types, codes and helper functions for the sync stall watchdog.
package ssw_pkg;

    typedef enum logic [2:0] {
        CFG_HDR_STALL_LIMIT = 3'd0,
        CFG_BLK_STALL_LIMIT = 3'd1,
        CFG_ESC_WINDOW_SECS = 3'd2,
        CFG_ESC_THRESHOLD   = 3'd3,
        CFG_PEER_FLOOR_MIN  = 3'd4,
        CFG_PEER_FLOOR_SECS = 3'd5,
        CFG_SYNC_GAP_BLOCKS = 3'd6,
        CFG_SYNC_GAP_SECS   = 3'd7
    } t_cfg_idx;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FIND    = 3'd1;
    localparam logic [2:0] ST_HEADERS = 3'd2;
    localparam logic [2:0] ST_BLOCKS  = 3'd3;
    localparam logic [2:0] ST_CONNECT = 3'd4;
    localparam logic [2:0] ST_REORG   = 3'd5;
    localparam logic [2:0] ST_AT_TIP  = 3'd6;

    localparam logic [2:0] REC_NONE         = 3'd0;
    localparam logic [2:0] REC_HEADER_STALL = 3'd1;
    localparam logic [2:0] REC_BLOCK_STALL  = 3'd2;
    localparam logic [2:0] REC_STUCK        = 3'd3;
    localparam logic [2:0] REC_HEADER_LAG   = 3'd4;
    localparam logic [2:0] REC_ESCALATION   = 3'd5;
    localparam logic [2:0] REC_PEER_FLOOR   = 3'd6;
    localparam logic [2:0] REC_SYNC_VIOL    = 3'd7;

    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_FIND_PEERS  = 3'd1;
    localparam logic [2:0] ACT_GO_HEADERS  = 3'd2;
    localparam logic [2:0] ACT_DEEP_RESET  = 3'd3;
    localparam logic [2:0] ACT_FULL_RESET  = 3'd4;
    localparam logic [2:0] ACT_DROP_UNHS   = 3'd5;
    localparam logic [2:0] ACT_REQUEUE     = 3'd6;

    localparam logic [31:0] LAG_MIN_SECS   = 32'd60;
    localparam logic [31:0] TIP_MIN_SECS   = 32'd120;
    localparam logic signed [33:0] LAG_BLOCKS = 34'sd500;
    localparam logic signed [33:0] TIP_BLOCKS = 34'sd144;

    typedef struct packed {
        logic [15:0] hdr_stall_limit;
        logic [15:0] blk_stall_limit;
        logic [15:0] esc_window_secs;
        logic [7:0]  esc_threshold;
        logic [7:0]  peer_floor_min;
        logic [15:0] peer_floor_secs;
        logic [15:0] sync_gap_blocks;
        logic [15:0] sync_gap_secs;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        now;
        logic [2:0]         st;
        logic [31:0]        dur;
        logic [7:0]         healthy;
        logic signed [31:0] chain;
        logic signed [31:0] hdr;
        logic signed [31:0] pmax;
    } t_tick;

    typedef struct packed {
        logic [31:0]        floor_first;
        logic [31:0]        gap_first;
        logic signed [31:0] prev_hdr;
        logic signed [31:0] prev_chain;
        logic [1:0]         esc_level;
        logic [7:0]         l1_fail;
        logic [31:0]        l1_start;
        logic [7:0]         l2_fail;
        logic [31:0]        l2_start;
        logic [7:0]         streak;
        logic               flag;
    } t_state;

    typedef struct packed {
        logic [2:0] recovery;
        logic [2:0] action;
        logic [1:0] level_now;
        logic       stall_escalated;
    } t_result;

    function automatic logic signed [33:0] f_sx34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    // signed elapsed time now - then, compared against an unsigned limit
    function automatic logic f_elapsed_gt(input logic [31:0] now, input logic [31:0] then_t,
                                          input logic [15:0] lim);
        logic signed [33:0] d;
        d = $signed({2'b00, now}) - $signed({2'b00, then_t});
        return d > $signed({18'b0, lim});
    endfunction

    function automatic logic [7:0] f_sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [9:0] f_stuck_limit(input logic [2:0] st);
        logic [9:0] lim;
        case (st)
            ST_FIND:    lim = 10'd120;
            ST_HEADERS: lim = 10'd600;
            ST_BLOCKS:  lim = 10'd600;
            ST_CONNECT: lim = 10'd180;
            ST_REORG:   lim = 10'd60;
            default:    lim = 10'd300;
        endcase
        return lim;
    endfunction

    function automatic t_state f_note(input t_state s, input logic [31:0] now);
        t_state r;
        r = s;
        if (s.esc_level <= 2'd1) begin
            if (s.l1_start == '0) r.l1_start = now;
            r.l1_fail   = f_sat_inc(s.l1_fail);
            r.esc_level = 2'd1;
        end else if (s.esc_level == 2'd2) begin
            if (s.l2_start == '0) r.l2_start = now;
            r.l2_fail = f_sat_inc(s.l2_fail);
        end
        return r;
    endfunction

endpackage

// ----- rtl/ssw_if.sv -----
// Channel interfaces: check tick input, result output and configuration write.
interface ssw_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_secs;
    logic [2:0]         sync_phase;
    logic [31:0]        state_secs;
    logic [7:0]         healthy_outbound;
    logic signed [31:0] chain_height;
    logic signed [31:0] header_height;
    logic signed [31:0] peer_max_height;
    logic [7:0]         peer_count;

    modport source (output valid, now_secs, sync_phase, state_secs, healthy_outbound,
                    chain_height, header_height, peer_max_height, peer_count,
                    input ready);
    modport sink (input valid, now_secs, sync_phase, state_secs, healthy_outbound,
                  chain_height, header_height, peer_max_height, peer_count,
                  output ready);
endinterface

interface ssw_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] recovery;
    logic [2:0] action;
    logic [1:0] level_now;
    logic       stall_escalated;

    modport source (output valid, recovery, action, level_now, stall_escalated,
                    input ready);
    modport sink (input valid, recovery, action, level_now, stall_escalated,
                  output ready);
endinterface

interface ssw_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/sync_stall_watchdog.sv -----
// Sync stall watchdog top level: input register, rule check, result register.
// Ticks wait in the input register until the result register is free; one tick per
// cycle moves on unless the output stalls. The watchdog state updates as a tick
// enters the result register, so consecutive ticks see each other's state changes.
// Reset: synchronous active low; clears the watchdog state, the channel valids and
// restores the configuration registers to their defaults.
module sync_stall_watchdog import ssw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssw_in_if.sink    i_in,
    ssw_out_if.source o_out,
    ssw_cfg_if.sink   i_cfg
);

    t_cfg    cfg;
    t_tick   r_in;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;
    logic    r_out_valid;
    logic    adv;

    ssw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ssw_check u_check (
        .i_cfg    (cfg),
        .i_tick   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.now     <= i_in.now_secs;
            r_in.st      <= i_in.sync_phase;
            r_in.dur     <= i_in.state_secs;
            r_in.healthy <= i_in.healthy_outbound;
            r_in.chain   <= i_in.chain_height;
            r_in.hdr     <= i_in.header_height;
            r_in.pmax    <= i_in.peer_max_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.floor_first <= '0;
            r_state.gap_first   <= '0;
            r_state.prev_hdr    <= -32'sd1;
            r_state.prev_chain  <= -32'sd1;
            r_state.esc_level   <= '0;
            r_state.l1_fail     <= '0;
            r_state.l1_start    <= '0;
            r_state.l2_fail     <= '0;
            r_state.l2_start    <= '0;
            r_state.streak      <= '0;
            r_state.flag        <= 1'b0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.recovery        = r_out.recovery;
    assign o_out.action          = r_out.action;
    assign o_out.level_now       = r_out.level_now;
    assign o_out.stall_escalated = r_out.stall_escalated;

endmodule

// ----- rtl/ssw_cfg_regs.sv -----
// Configuration register file with reset values.
module ssw_cfg_regs import ssw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssw_cfg_if.sink     i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_stall_limit <= 16'd300;
            r_cfg.blk_stall_limit <= 16'd300;
            r_cfg.esc_window_secs <= 16'd1800;
            r_cfg.esc_threshold   <= 8'd3;
            r_cfg.peer_floor_min  <= 8'd3;
            r_cfg.peer_floor_secs <= 16'd60;
            r_cfg.sync_gap_blocks <= 16'd100;
            r_cfg.sync_gap_secs   <= 16'd600;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_HDR_STALL_LIMIT: r_cfg.hdr_stall_limit <= i_cfg.data;
                CFG_BLK_STALL_LIMIT: r_cfg.blk_stall_limit <= i_cfg.data;
                CFG_ESC_WINDOW_SECS: r_cfg.esc_window_secs <= i_cfg.data;
                CFG_ESC_THRESHOLD:   r_cfg.esc_threshold   <= i_cfg.data[7:0];
                CFG_PEER_FLOOR_MIN:  r_cfg.peer_floor_min  <= i_cfg.data[7:0];
                CFG_PEER_FLOOR_SECS: r_cfg.peer_floor_secs <= i_cfg.data;
                CFG_SYNC_GAP_BLOCKS: r_cfg.sync_gap_blocks <= i_cfg.data;
                CFG_SYNC_GAP_SECS:   r_cfg.sync_gap_secs   <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/ssw_check.sv -----
// Rule evaluation for one check tick: next watchdog state and result.
module ssw_check import ssw_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_tick   i_tick,
    input  t_state  i_state,
    output t_state  o_state,
    output t_result o_result
);

    t_state     s;
    logic       done;
    logic       lvl_found;
    logic [1:0] lvl;
    logic [2:0] rec;
    logic [2:0] act;
    logic       pmax_pos;
    logic       chain_ok;
    logic       hdr_ok;

    assign pmax_pos = !i_tick.pmax[31] && (i_tick.pmax != '0);
    assign chain_ok = !i_tick.chain[31];
    assign hdr_ok   = !i_tick.hdr[31];

    always_comb begin
        s         = i_state;
        done      = 1'b0;
        lvl_found = 1'b0;
        lvl       = 2'd1;
        rec       = REC_NONE;
        act       = ACT_NONE;

        // peer floor
        if (i_tick.healthy < i_cfg.peer_floor_min) begin
            if (s.floor_first == '0) s.floor_first = i_tick.now;
            if (f_elapsed_gt(i_tick.now, s.floor_first, i_cfg.peer_floor_secs)) begin
                s.floor_first = i_tick.now;
                s    = f_note(s, i_tick.now);
                act  = ACT_DROP_UNHS;
                rec  = REC_PEER_FLOOR;
                done = 1'b1;
            end
        end else begin
            s.floor_first = '0;
        end

        // sync gap violation
        if (!done) begin
            if (pmax_pos && chain_ok &&
                (f_sx34(i_tick.pmax) - f_sx34(i_tick.chain)) >
                $signed({18'b0, i_cfg.sync_gap_blocks})) begin
                if (s.gap_first == '0) s.gap_first = i_tick.now;
                if (f_elapsed_gt(i_tick.now, s.gap_first, i_cfg.sync_gap_secs)) begin
                    s.esc_level = 2'd2;
                    s.gap_first = i_tick.now;
                    s    = f_note(s, i_tick.now);
                    act  = ACT_DEEP_RESET;
                    rec  = REC_SYNC_VIOL;
                    done = 1'b1;
                end
            end else begin
                s.gap_first = '0;
            end
        end

        // escalation
        if (!done) begin
            lvl = (s.esc_level != 2'd0) ? s.esc_level : 2'd1;
            if (s.esc_level >= 2'd2) begin
                if (f_elapsed_gt(i_tick.now, s.l2_start, i_cfg.esc_window_secs)) begin
                    s.l2_fail  = '0;
                    s.l2_start = i_tick.now;
                end
                if (s.l2_fail >= i_cfg.esc_threshold) begin
                    lvl       = 2'd3;
                    lvl_found = 1'b1;
                end
            end
            if (!lvl_found && s.esc_level >= 2'd1) begin
                if (f_elapsed_gt(i_tick.now, s.l1_start, i_cfg.esc_window_secs)) begin
                    s.l1_fail  = '0;
                    s.l1_start = i_tick.now;
                end
                if (s.l1_fail >= i_cfg.esc_threshold) lvl = 2'd2;
            end
            if (lvl == 2'd3 && s.esc_level != 2'd3) begin
                s.esc_level = 2'd3;
                s.l2_fail   = '0;
                s.l2_start  = '0;
                s    = f_note(s, i_tick.now);
                act  = ACT_FULL_RESET;
                rec  = REC_ESCALATION;
                done = 1'b1;
            end else if (lvl >= 2'd2 && s.esc_level < 2'd2) begin
                s.esc_level = 2'd2;
                s    = f_note(s, i_tick.now);
                act  = ACT_DEEP_RESET;
                rec  = REC_ESCALATION;
                done = 1'b1;
            end
        end

        // header stall
        if (!done) begin
            if (i_tick.st == ST_HEADERS && i_tick.dur > {16'b0, i_cfg.hdr_stall_limit}) begin
                if (hdr_ok && i_tick.hdr <= s.prev_hdr) begin
                    s          = f_note(s, i_tick.now);
                    s.prev_hdr = -32'sd1;
                    s.streak   = f_sat_inc(s.streak);
                    if (s.streak >= 8'd2) s.flag = 1'b1;
                    act  = ACT_FIND_PEERS;
                    rec  = REC_HEADER_STALL;
                    done = 1'b1;
                end else begin
                    s.prev_hdr = i_tick.hdr;
                end
            end else if (i_tick.st != ST_HEADERS) begin
                s.prev_hdr = -32'sd1;
                s.streak   = '0;
                s.flag     = 1'b0;
            end
        end

        // header lag
        if (!done) begin
            if (i_tick.st == ST_BLOCKS && i_tick.dur > LAG_MIN_SECS && hdr_ok &&
                !i_tick.pmax[31] &&
                f_sx34(i_tick.hdr) < (f_sx34(i_tick.pmax) - LAG_BLOCKS)) begin
                s    = f_note(s, i_tick.now);
                act  = ACT_GO_HEADERS;
                rec  = REC_HEADER_LAG;
                done = 1'b1;
            end
        end

        // block stall
        if (!done) begin
            if (i_tick.st == ST_BLOCKS && i_tick.dur > {16'b0, i_cfg.blk_stall_limit}) begin
                if (chain_ok && i_tick.chain <= s.prev_chain) begin
                    s            = f_note(s, i_tick.now);
                    s.prev_chain = -32'sd1;
                    act  = ACT_REQUEUE;
                    rec  = REC_BLOCK_STALL;
                    done = 1'b1;
                end else begin
                    s.prev_chain = i_tick.chain;
                end
            end else if (i_tick.st != ST_BLOCKS) begin
                s.prev_chain = -32'sd1;
            end
        end

        // stale tip
        if (!done) begin
            if (i_tick.st == ST_AT_TIP && i_tick.dur > TIP_MIN_SECS && pmax_pos && chain_ok &&
                f_sx34(i_tick.pmax) > (f_sx34(i_tick.chain) + TIP_BLOCKS)) begin
                s    = f_note(s, i_tick.now);
                act  = ACT_GO_HEADERS;
                rec  = REC_STUCK;
                done = 1'b1;
            end
        end

        // per-state stuck timeout
        if (!done) begin
            if (i_tick.st != ST_AT_TIP &&
                i_tick.dur > {22'b0, f_stuck_limit(i_tick.st)}) begin
                s   = f_note(s, i_tick.now);
                act = ACT_GO_HEADERS;
                rec = REC_STUCK;
            end
        end
    end

    assign o_state                  = s;
    assign o_result.recovery        = rec;
    assign o_result.action          = act;
    assign o_result.level_now       = s.esc_level;
    assign o_result.stall_escalated = s.flag;

endmodule

// ----- tb/ssw_checker.sv -----
`timescale 1ns / 100ps
// Watchdog checker: mirrors the rules on accepted ticks and compares every result beat.
module ssw_checker import ssw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ssw_in_if    i_in,
    ssw_out_if   i_out,
    ssw_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam longint LAG_AFTER_SECS = 60;
    localparam longint LAG_GAP_BLOCKS = 500;
    localparam longint TIP_AFTER_SECS = 120;
    localparam longint TIP_GAP_BLOCKS = 144;

    t_cfg        cfg;
    logic [31:0] floor_t0;
    logic [31:0] gap_t0;
    longint      prev_hdr;
    longint      prev_chain;
    logic [1:0]  esc_level;
    logic [7:0]  l1_fails;
    logic [31:0] l1_start;
    logic [7:0]  l2_fails;
    logic [31:0] l2_start;
    logic [7:0]  streak;
    logic        stall_flag;
    t_result     pending_verdicts[$];

    function automatic longint widen(input logic [31:0] v);
        return longint'({32'd0, v});
    endfunction

    // elapsed time is signed, so a clock going backwards never exceeds a limit
    function automatic bit past_limit(input logic [31:0] now_t, input logic [31:0] then_t,
                                      input logic [31:0] lim);
        return (widen(now_t) - widen(then_t)) > widen(lim);
    endfunction

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic longint stuck_secs(input logic [2:0] st);
        case (st)
            ST_FIND:    return 120;
            ST_HEADERS: return 600;
            ST_BLOCKS:  return 600;
            ST_CONNECT: return 180;
            ST_REORG:   return 60;
            default:    return 300;
        endcase
    endfunction

    function automatic void count_failure(input logic [31:0] now_t);
        if (esc_level <= 2'd1) begin
            if (l1_start == '0) l1_start = now_t;
            l1_fails  = bump(l1_fails);
            esc_level = 2'd1;
        end else if (esc_level == 2'd2) begin
            if (l2_start == '0) l2_start = now_t;
            l2_fails = bump(l2_fails);
        end
    endfunction

    function automatic logic [1:0] wanted_level(input logic [31:0] now_t);
        if (esc_level >= 2'd2) begin
            if (past_limit(now_t, l2_start, cfg.esc_window_secs)) begin
                l2_fails = '0;
                l2_start = now_t;
            end
            if (l2_fails >= cfg.esc_threshold) return 2'd3;
        end
        if (esc_level >= 2'd1) begin
            if (past_limit(now_t, l1_start, cfg.esc_window_secs)) begin
                l1_fails = '0;
                l1_start = now_t;
            end
            if (l1_fails >= cfg.esc_threshold) return 2'd2;
        end
        return (esc_level > 2'd0) ? esc_level : 2'd1;
    endfunction

    function automatic logic [2:0] judge_tick(input t_tick t, output logic [2:0] act);
        longint     dur;
        longint     chain;
        longint     hdr;
        longint     pmax;
        logic [1:0] want;
        dur   = widen(t.dur);
        chain = $signed(t.chain);
        hdr   = $signed(t.hdr);
        pmax  = $signed(t.pmax);
        act   = ACT_NONE;

        if (t.healthy < cfg.peer_floor_min) begin
            if (floor_t0 == '0) floor_t0 = t.now;
            if (past_limit(t.now, floor_t0, cfg.peer_floor_secs)) begin
                floor_t0 = t.now;
                count_failure(t.now);
                act = ACT_DROP_UNHS;
                return REC_PEER_FLOOR;
            end
        end else begin
            floor_t0 = '0;
        end

        if (pmax > 0 && chain >= 0 && pmax - chain > widen(cfg.sync_gap_blocks)) begin
            if (gap_t0 == '0) gap_t0 = t.now;
            if (past_limit(t.now, gap_t0, cfg.sync_gap_secs)) begin
                esc_level = 2'd2;
                gap_t0    = t.now;
                count_failure(t.now);
                act = ACT_DEEP_RESET;
                return REC_SYNC_VIOL;
            end
        end else begin
            gap_t0 = '0;
        end

        want = wanted_level(t.now);
        if (want >= 2'd3 && esc_level < 2'd3) begin
            esc_level = 2'd3;
            l2_fails  = '0;
            l2_start  = '0;
            count_failure(t.now);
            act = ACT_FULL_RESET;
            return REC_ESCALATION;
        end
        if (want >= 2'd2 && esc_level < 2'd2) begin
            esc_level = 2'd2;
            count_failure(t.now);
            act = ACT_DEEP_RESET;
            return REC_ESCALATION;
        end

        if (t.st == ST_HEADERS && dur > widen(cfg.hdr_stall_limit)) begin
            if (hdr >= 0 && hdr <= prev_hdr) begin
                count_failure(t.now);
                prev_hdr = -1;
                streak   = bump(streak);
                if (streak >= 8'd2) stall_flag = 1'b1;
                act = ACT_FIND_PEERS;
                return REC_HEADER_STALL;
            end
            prev_hdr = hdr;
        end else if (t.st != ST_HEADERS) begin
            prev_hdr   = -1;
            streak     = '0;
            stall_flag = 1'b0;
        end

        if (t.st == ST_BLOCKS && dur > LAG_AFTER_SECS && hdr >= 0 && pmax >= 0 &&
            hdr < pmax - LAG_GAP_BLOCKS) begin
            count_failure(t.now);
            act = ACT_GO_HEADERS;
            return REC_HEADER_LAG;
        end

        if (t.st == ST_BLOCKS && dur > widen(cfg.blk_stall_limit)) begin
            if (chain >= 0 && chain <= prev_chain) begin
                count_failure(t.now);
                prev_chain = -1;
                act = ACT_REQUEUE;
                return REC_BLOCK_STALL;
            end
            prev_chain = chain;
        end else if (t.st != ST_BLOCKS) begin
            prev_chain = -1;
        end

        if (t.st == ST_AT_TIP && dur > TIP_AFTER_SECS && pmax > 0 && chain >= 0 &&
            pmax > chain + TIP_GAP_BLOCKS) begin
            count_failure(t.now);
            act = ACT_GO_HEADERS;
            return REC_STUCK;
        end

        if (t.st != ST_AT_TIP && dur > stuck_secs(t.st)) begin
            count_failure(t.now);
            act = ACT_GO_HEADERS;
            return REC_STUCK;
        end
        return REC_NONE;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_tick      tk;
        t_result    want_r;
        logic [2:0] act;
        if (!i_rst_n) begin
            cfg.hdr_stall_limit = 16'd300;
            cfg.blk_stall_limit = 16'd300;
            cfg.esc_window_secs = 16'd1800;
            cfg.esc_threshold   = 8'd3;
            cfg.peer_floor_min  = 8'd3;
            cfg.peer_floor_secs = 16'd60;
            cfg.sync_gap_blocks = 16'd100;
            cfg.sync_gap_secs   = 16'd600;
            floor_t0   = '0;
            gap_t0     = '0;
            prev_hdr   = -1;
            prev_chain = -1;
            esc_level  = '0;
            l1_fails   = '0;
            l1_start   = '0;
            l2_fails   = '0;
            l2_start   = '0;
            streak     = '0;
            stall_flag = 1'b0;
            pending_verdicts.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pending_verdicts.size() == 0) begin
                    $error("result beat with no tick outstanding");
                    o_fail_count++;
                end else begin
                    want_r = pending_verdicts.pop_front();
                    check_field("recovery", want_r.recovery, i_out.recovery);
                    check_field("action", want_r.action, i_out.action);
                    check_field("level_now", want_r.level_now, i_out.level_now);
                    check_field("stall_escalated", want_r.stall_escalated,
                                i_out.stall_escalated);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_HDR_STALL_LIMIT: cfg.hdr_stall_limit = i_cfg.data;
                    CFG_BLK_STALL_LIMIT: cfg.blk_stall_limit = i_cfg.data;
                    CFG_ESC_WINDOW_SECS: cfg.esc_window_secs = i_cfg.data;
                    CFG_ESC_THRESHOLD:   cfg.esc_threshold   = i_cfg.data[7:0];
                    CFG_PEER_FLOOR_MIN:  cfg.peer_floor_min  = i_cfg.data[7:0];
                    CFG_PEER_FLOOR_SECS: cfg.peer_floor_secs = i_cfg.data;
                    CFG_SYNC_GAP_BLOCKS: cfg.sync_gap_blocks = i_cfg.data;
                    CFG_SYNC_GAP_SECS:   cfg.sync_gap_secs   = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                tk.now     = i_in.now_secs;
                tk.st      = i_in.sync_phase;
                tk.dur     = i_in.state_secs;
                tk.healthy = i_in.healthy_outbound;
                tk.chain   = i_in.chain_height;
                tk.hdr     = i_in.header_height;
                tk.pmax    = i_in.peer_max_height;
                want_r.recovery        = judge_tick(tk, act);
                want_r.action          = act;
                want_r.level_now       = esc_level;
                want_r.stall_escalated = stall_flag;
                pending_verdicts.push_back(want_r);
            end
        end
        o_pending = pending_verdicts.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, tick and configuration stimulus, and the final verdict.
module tb_top import ssw_pkg::*; ();

    localparam int         CYCLE_LIMIT = 300000;
    localparam logic [2:0] ST_OTHER    = 3'd7;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          pending;
    int          burst_left;
    bit          no_gaps;
    int          hold_requests;
    int          cycle_count;
    logic [31:0] sim_now;
    int          chain_base;

    ssw_in_if  in_ch ();
    ssw_out_if out_ch ();
    ssw_cfg_if cfg_ch ();

    sync_stall_watchdog dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ssw_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // result side: the stall rate is redrawn from a fixed set of percentages; long holds on request
    initial begin : result_sink
        int cyc;
        int stall_pct;
        int hold_left;
        int holds_served;
        cyc          = 0;
        stall_pct    = 0;
        hold_left    = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (cyc % 97 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            cyc++;
            if (holds_served != hold_requests) begin
                hold_left = 150;
                holds_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_tick(input t_tick tk, input logic [7:0] pc);
        if (!no_gaps && burst_left == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        in_ch.valid            = 1'b1;
        in_ch.now_secs         = tk.now;
        in_ch.sync_phase       = tk.st;
        in_ch.state_secs       = tk.dur;
        in_ch.healthy_outbound = tk.healthy;
        in_ch.chain_height     = tk.chain;
        in_ch.header_height    = tk.hdr;
        in_ch.peer_max_height  = tk.pmax;
        in_ch.peer_count       = pc;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic tick(input logic [31:0] now_t, input logic [2:0] st, input logic [31:0] dur,
                        input logic [7:0] healthy, input int chain, input int hdr,
                        input int pmax);
        t_tick tk;
        tk.now     = now_t;
        tk.st      = st;
        tk.dur     = dur;
        tk.healthy = healthy;
        tk.chain   = chain;
        tk.hdr     = hdr;
        tk.pmax    = pmax;
        send_tick(tk, 8'($urandom));
    endtask

    function automatic int any_height();
        return ($urandom_range(0, 9) == 0) ? -1 : int'($urandom_range(0, 32'h7FFFFFFF));
    endfunction

    // episodes of one sync state with a running clock and mostly coherent heights
    task automatic send_random(input int count);
        t_tick       tk;
        logic [31:0] ep_dur;
        logic [2:0]  ep_state;
        logic [7:0]  ep_healthy;
        int          ep_len;
        int          sel;
        int          lead;
        int          spread;
        bit          frozen;
        while (count > 0) begin
            ep_len   = $urandom_range(1, 10);
            sel      = $urandom_range(0, 11);
            ep_state = (sel < 8) ? 3'(sel) : ((sel < 10) ? ST_HEADERS : ST_BLOCKS);
            case ($urandom_range(0, 4))
                0:       ep_dur = $urandom_range(0, 60);
                1:       ep_dur = $urandom_range(50, 700);
                2:       ep_dur = $urandom_range(0, 3000);
                3:       ep_dur = $urandom_range(0, 70000);
                default: ep_dur = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       spread = $urandom_range(0, 50);
                1:       spread = $urandom_range(80, 170);
                2:       spread = $urandom_range(400, 700);
                default: spread = $urandom_range(1000, 200000);
            endcase
            lead       = $urandom_range(0, 20);
            frozen     = $urandom_range(0, 1);
            ep_healthy = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4))
                                                      : 8'($urandom_range(3, 255));
            while (ep_len > 0 && count > 0) begin
                sel = $urandom_range(0, 19);
                if (sel < 18) begin
                    if (sel < 14)      lead = lead;
                    ep_dur  += (sel < 14) ? $urandom_range(1, 200)
                             : (sel < 17) ? $urandom_range(200, 5000)
                                          : $urandom_range(5000, 100000);
                    sim_now = sim_now + ((sel < 14) ? 32'd20 : 32'd0) + $urandom_range(1, 300);
                end else if (sel == 18) begin
                    sim_now = sim_now - $urandom_range(1, 3000);
                end else begin
                    sim_now = $urandom;
                end
                if (sim_now == '0) sim_now = 32'd1;
                if (!frozen || $urandom_range(0, 9) == 0) chain_base += $urandom_range(0, 3);
                tk.now     = sim_now;
                tk.st      = ep_state;
                tk.dur     = ep_dur;
                tk.healthy = ep_healthy;
                tk.chain   = chain_base;
                tk.hdr     = chain_base + lead;
                tk.pmax    = chain_base + spread;
                if ($urandom_range(0, 24) == 0) tk.chain = -1;
                if ($urandom_range(0, 24) == 0) tk.hdr = -1;
                if ($urandom_range(0, 24) == 0) tk.pmax = -1;
                if ($urandom_range(0, 9) == 0) begin
                    tk.now     = $urandom;
                    if (tk.now == '0) tk.now = 32'd1;
                    tk.st      = 3'($urandom);
                    tk.dur     = $urandom;
                    tk.healthy = 8'($urandom);
                    tk.chain   = any_height();
                    tk.hdr     = any_height();
                    tk.pmax    = any_height();
                end
                send_tick(tk, 8'($urandom));
                ep_len--;
                count--;
            end
        end
    endtask

    task automatic wait_idle();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_config(input logic [15:0] vals [8]);
        cfg_ch.valid = 1'b1;
        for (int i = 0; i < 8; i++) begin
            cfg_ch.index = 3'(i);
            cfg_ch.data  = vals[i];
            do @(posedge clk); while (!cfg_ch.ready);
            @(negedge clk);
        end
        cfg_ch.valid = 1'b0;
    endtask

    initial begin : stimulus
        logic [15:0] regs [8];
        rst_n                  = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.now_secs         = '0;
        in_ch.sync_phase       = ST_IDLE;
        in_ch.state_secs       = '0;
        in_ch.healthy_outbound = '0;
        in_ch.chain_height     = '0;
        in_ch.header_height    = '0;
        in_ch.peer_max_height  = '0;
        in_ch.peer_count       = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = CFG_HDR_STALL_LIMIT;
        cfg_ch.data            = '0;
        burst_left             = 0;
        no_gaps                = 1'b0;
        hold_requests          = 0;
        sim_now                = 32'd5000;
        chain_base             = $urandom_range(1000, 1000000);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed ticks with the reset configuration
        tick(32'd1000, ST_IDLE, 32'd0, 8'd0, -1, -1, -1);
        tick(32'd1061, ST_IDLE, 32'd5, 8'd1, -1, -1, -1);
        tick(32'd1100, ST_FIND, 32'd0, 8'd255, 0, 0, 1000);
        tick(32'd1701, ST_FIND, 32'd10, 8'd255, 0, 0, 1000);
        tick(32'd1800, ST_HEADERS, 32'd400, 8'd8, 100, 50, 100);
        tick(32'd1810, ST_HEADERS, 32'd410, 8'd8, 100, 50, 100);
        tick(32'd1820, ST_HEADERS, 32'd420, 8'd8, 100, 50, 100);
        tick(32'd1830, ST_HEADERS, 32'd430, 8'd8, 100, 50, 100);
        tick(32'd1840, ST_BLOCKS, 32'd100, 8'd8, 10, 10, 1000);
        tick(32'd1850, ST_BLOCKS, 32'd400, 8'd8, 600, 600, 600);
        tick(32'd1860, ST_BLOCKS, 32'd410, 8'd8, 600, 600, 600);
        tick(32'd1870, ST_AT_TIP, 32'd200, 8'd8, 0, 0, 200);
        tick(32'd1880, ST_REORG, 32'd61, 8'd8, 5, 5, 5);
        tick(32'd1890, ST_CONNECT, 32'd181, 8'd8, 5, 5, 5);
        tick(32'd1900, ST_OTHER, 32'd301, 8'd8, 5, 5, 5);
        tick(32'hFFFF_FFFF, ST_AT_TIP, 32'hFFFF_FFFF, 8'd255, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF);
        tick(32'd1, ST_IDLE, 32'd0, 8'd0, -1, -1, -1);
        tick(32'd5, ST_AT_TIP, 32'd0, 8'd8, 32'h7FFF_FFFF, -1, -1);
        tick(32'd7, ST_AT_TIP, 32'd121, 8'd8, 0, 0, 32'h7FFF_FFFF);

        send_random(200);
        hold_requests++;
        no_gaps = 1'b1;
        send_random(40);
        no_gaps = 1'b0;
        wait_idle();
        send_random(60);

        wait_idle();
        foreach (regs[i]) regs[i] = 16'd1;
        regs[CFG_PEER_FLOOR_MIN]  = 16'd0;
        regs[CFG_SYNC_GAP_BLOCKS] = 16'd0;
        load_config(regs);
        send_random(130);

        wait_idle();
        foreach (regs[i]) regs[i] = 16'hFFFF;
        regs[CFG_ESC_THRESHOLD]  = 16'h00FF;
        regs[CFG_PEER_FLOOR_MIN] = 16'h00FF;
        load_config(regs);
        send_random(130);

        // out of range values are allowed here, a zero threshold among them
        wait_idle();
        foreach (regs[i]) begin
            case ($urandom_range(0, 5))
                0:       regs[i] = 16'd0;
                1:       regs[i] = 16'hFFFF;
                default: regs[i] = 16'($urandom_range(1, 2000));
            endcase
        end
        regs[CFG_ESC_THRESHOLD]  = 16'($urandom_range(0, 6)) | 16'($urandom & 32'hFF00);
        regs[CFG_PEER_FLOOR_MIN] = 16'($urandom_range(0, 8));
        load_config(regs);
        send_random(100);
        hold_requests++;
        no_gaps = 1'b1;
        send_random(40);
        no_gaps = 1'b0;

        wait_idle();
        regs[CFG_HDR_STALL_LIMIT] = 16'd120;
        regs[CFG_BLK_STALL_LIMIT] = 16'd200;
        regs[CFG_ESC_WINDOW_SECS] = 16'd900;
        regs[CFG_ESC_THRESHOLD]   = 16'd2;
        regs[CFG_PEER_FLOOR_MIN]  = 16'd2;
        regs[CFG_PEER_FLOOR_SECS] = 16'd30;
        regs[CFG_SYNC_GAP_BLOCKS] = 16'd150;
        regs[CFG_SYNC_GAP_SECS]   = 16'd300;
        load_config(regs);
        send_random(50);

        wait_idle();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
